FILE: hw/rtl/lwts_pkg.sv
// ----------------------------------------------------------------------------
// lwts_pkg - shared types for the longest target-sum window block
// Element and target widths fixed by the stream and register formats.
// ----------------------------------------------------------------------------
package lwts_pkg;

    localparam int ELEM_W   = 16;
    localparam int TARGET_W = 26;

    typedef logic [ELEM_W-1:0]   elem_t;
    typedef logic [TARGET_W-1:0] target_t;

endpackage

FILE: hw/rtl/longest_window_with_target_sum.sv
// ----------------------------------------------------------------------------
// longest_window_with_target_sum - longest contiguous run equal to a target
// Sliding window over a stream of non-negative elements; reports the
// longest window whose sum equals target_sum when the array closes.
// ----------------------------------------------------------------------------
//
//  channel   signals                              role
//  --------  -----------------------------------  ------------------------------
//  in        in_valid in_ready element last       one element request per array slot
//  out       out_valid out_ready best_length      one result request per array
//            overflow
//  cfg       cfg_wr_en cfg_wr_data                target_sum write, no wait
//
//  Steps: an element that fits is added to the sum in the idle state, then
//  checked; each element dropped from the window front takes a RAM read in
//  the check state, then a subtract on the shared adder. Each element is
//  dropped at most once. An element past MAX_LEN is dropped and flagged in
//  the idle state. A last element leads to the finish state, which loads the
//  result register and waits while that register is still full. Reset clears
//  all control state; window RAM contents are never read before written and
//  need no clearing pass. in_ready is high only in the idle state; a stalled
//  result holds the block in the finish state until out_ready frees the output register.
//
module longest_window_with_target_sum #(
    parameter int MAX_LEN = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // element requests
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lwts_pkg::elem_t                element,
    input  logic                           last,
    // result requests
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [$clog2(MAX_LEN+1)-1:0]   best_length,
    output logic                           overflow,
    // configuration
    input  logic                           cfg_wr_en,
    input  lwts_pkg::target_t              cfg_wr_data
);

    import lwts_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    // Sum must hold MAX_LEN full-scale elements and the whole target range.
    localparam int SUM_W = (ELEM_W + CNT_W > TARGET_W) ? ELEM_W + CNT_W : TARGET_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SUB   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
        ring_next = (pos == IDX_W'(MAX_LEN - 1)) ? '0 : pos + 1'b1;
    endfunction

    // Control and window state
    logic [1:0]       state_reg, state_next;
    target_t          target_reg;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             ovf_reg, ovf_next;
    logic             last_reg, last_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] out_len_reg;
    logic             out_ovf_reg;

    logic             in_fire;
    logic             full;
    logic [SUM_W-1:0] target_ext;
    logic             sum_gt;
    logic             sum_eq;
    logic             drop;
    logic             out_free;
    logic             out_load;

    // Shared add/subtract unit
    logic             alu_sub;
    logic [SUM_W-1:0] alu_op;
    logic [SUM_W-1:0] alu_b;
    logic [SUM_W-1:0] alu_sum;

    // Window RAM
    logic             ram_we;
    logic             ram_re;
    elem_t            ram_rdata;

    lwts_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_LEN)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (back_reg),
        .wdata (element),
        .re    (ram_re),
        .raddr (front_reg),
        .rdata (ram_rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign full       = (seen_reg == CNT_W'(MAX_LEN));
    assign target_ext = SUM_W'(target_reg);
    assign sum_gt     = (sum_reg > target_ext);
    assign sum_eq     = (sum_reg == target_ext);
    assign drop       = (count_reg != '0) && sum_gt;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_load   = (state_reg == ST_FIN) && out_free;

    // Append on accept unless past MAX_LEN, issue the front read while the window is over target.
    assign ram_we = in_fire && !full;
    assign ram_re = (state_reg == ST_CHECK) && drop;

    // Add the new element, or subtract the front element read last cycle.
    assign alu_sub = (state_reg == ST_SUB);
    assign alu_op  = alu_sub ? SUM_W'(ram_rdata) : SUM_W'(element);
    assign alu_b   = alu_sub ? ~alu_op : alu_op;
    assign alu_sum = sum_reg + alu_b + SUM_W'(alu_sub);

    assign out_valid   = out_valid_reg;
    assign best_length = out_len_reg;
    assign overflow    = out_ovf_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        seen_next  = seen_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = last;
                    if (full)
                    begin
                        // Past MAX_LEN: drop the element, flag it.
                        ovf_next   = 1'b1;
                        state_next = last ? ST_FIN : ST_IDLE;
                    end
                    else
                    begin
                        seen_next  = seen_reg + 1'b1;
                        back_next  = ring_next(back_reg);
                        count_next = count_reg + 1'b1;
                        sum_next   = alu_sum;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (drop)
                begin
                    state_next = ST_SUB;
                end
                else
                begin
                    if (sum_eq && (count_reg > best_reg))
                    begin
                        best_next = count_reg;
                    end
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_SUB:
            begin
                sum_next   = alu_sum;
                front_next = ring_next(front_reg);
                count_next = count_reg - 1'b1;
                state_next = ST_CHECK;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    // Result moves to the output register; clear for the next array.
                    front_next = '0;
                    back_next  = '0;
                    count_next = '0;
                    sum_next   = '0;
                    best_next  = '0;
                    seen_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            seen_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            best_reg      <= best_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload, loaded with its valid
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_len_reg <= best_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= seen_reg)
        else $error("window holds more elements than were accepted");

    a_best_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg <= seen_reg)
        else $error("best length exceeds accepted element count");

    a_sub_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUB) |-> (count_reg != '0))
        else $error("front drop from an empty window");

    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (seen_reg == '0) && (count_reg == '0) && out_valid_reg)
        else $error("array state not cleared after result load");
`endif

endmodule

FILE: hw/rtl/lwts_ram.sv
// ----------------------------------------------------------------------------
// lwts_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lwts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the longest target-sum window block
// Streams arrays of elements under several target_sum settings, predicts the
// longest matching window of each array in a scoreboard and checks every
// result request field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    import lwts_pkg::*;

    localparam int      WINDOW_DEPTH    = 1024;
    localparam int      LENGTH_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int      CLK_PERIOD      = 4;
    localparam int      RESET_CYCLES    = 12;
    localparam int      SETTLE_CYCLES   = 64;     // idle margin before a target write
    localparam int      HOLD_OFF_CYCLES = 400;    // long receiver stall
    localparam int      STALL_LIMIT     = 20000;  // cycles with no request moving
    localparam int      PHASE_ITEMS     = 50;
    localparam int      RANDOM_PHASES   = 6;
    localparam target_t TARGET_TOP      = 26'd67107840;

    typedef logic [LENGTH_W-1:0] length_t;

    typedef struct packed {
        length_t best_length;
        logic    overflow;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the window state, one expected outcome per array
    // ------------------------------------------------------------------------
    class window_scoreboard;
        target_t         target;
        elem_t           ring [WINDOW_DEPTH];
        int unsigned     head;
        int unsigned     tail;
        int unsigned     depth;
        int unsigned     seen;
        int unsigned     best;
        longint unsigned sum;
        bit              spilled;
        outcome_t        awaited [$];
        int              failures;

        function new();
            target   = '0;
            failures = 0;
            clear();
        endfunction

        function void clear();
            head    = 0;
            tail    = 0;
            depth   = 0;
            seen    = 0;
            best    = 0;
            sum     = 0;
            spilled = 1'b0;
        endfunction

        // Apply one accepted element request; queue the outcome when it closes.
        function void note_request(elem_t value, bit closes);
            outcome_t result;
            if (seen >= WINDOW_DEPTH) begin
                spilled = 1'b1;
            end
            else begin
                seen++;
                ring[tail] = value;
                tail       = (tail + 1) % WINDOW_DEPTH;
                depth++;
                sum += value;
                // drop from the front until the window sum no longer exceeds the target
                while (depth > 0 && sum > target) begin
                    sum -= ring[head];
                    head = (head + 1) % WINDOW_DEPTH;
                    depth--;
                end
                if (sum == target && depth > best)
                    best = depth;
            end
            if (closes) begin
                result.best_length = length_t'(best);
                result.overflow    = spilled;
                awaited = {awaited, result};
                clear();
            end
        endfunction

        function void complain(string msg);
            failures++;
            if (failures <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_result(length_t len, logic ovf);
            outcome_t want;
            if (awaited.size() == 0) begin
                complain($sformatf("unexpected result best_length=%0d overflow=%0b",
                                   len, ovf));
                return;
            end
            want = awaited.pop_front();
            if (len !== want.best_length)
                complain($sformatf("best_length expected %0d actual %0d",
                                   want.best_length, len));
            if (ovf !== want.overflow)
                complain($sformatf("overflow expected %0b actual %0b",
                                   want.overflow, ovf));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    elem_t   element;
    logic    last;
    logic    out_valid;
    logic    out_ready;
    length_t best_length;
    logic    overflow;
    logic    cfg_wr_en;
    target_t cfg_wr_data;

    window_scoreboard sb = new();

    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_odds     = 0;   // 1-in-N chance of a sender gap, 0 = none
    int unsigned stall_odds   = 0;   // 1-in-N chance of a receiver stall, 0 = none
    bit          hold_off_req = 1'b0;

    longest_window_with_target_sum #(
        .MAX_LEN(WINDOW_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .element     (element),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .best_length (best_length),
        .overflow    (overflow),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one element request and hold it until accepted. Valid is left high
    // on return so that a following request can go out back to back; the next
    // call, or close_inputs, decides in this same time step.
    task automatic send_request(input elem_t value, input bit closes);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        element  <= value;
        last     <= closes;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(value, closes);
        items_sent++;
    endtask

    // Drop valid in the step of the last acceptance.
    task automatic close_inputs();
        in_valid <= 1'b0;
    endtask

    // Send a whole array; the final element carries last.
    task automatic send_sequence(input elem_t values [$]);
        foreach (values[i])
            send_request(values[i], i == values.size() - 1);
    endtask

    // Write target_sum only once the block has drained and gone idle.
    task automatic set_target(input target_t value);
        close_inputs();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.target    = value;
    endtask

    // Bias elements toward the target so that matching windows show up often,
    // with zeros, full-range values and the all-ones value mixed in.
    function automatic elem_t random_element(target_t goal);
        int unsigned cap;
        cap = (goal > 65535) ? 65535 : goal;
        case ($urandom_range(0, 9))
            0, 1:       return '0;
            2, 3, 4, 5: return elem_t'($urandom_range(0, cap / 3 + 1));
            6, 7:       return elem_t'($urandom_range(0, cap));
            8:          return elem_t'($urandom_range(0, 65535));
            default:    return '1;
        endcase
    endfunction

    // Mostly short arrays; now and then a longer one to exercise deep drops.
    task automatic send_random_array();
        int unsigned count;
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
                                            : $urandom_range(1, 12);
        for (int unsigned i = 0; i < count; i++)
            send_request(random_element(sb.target), i == count - 1);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Check every accepted result request against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(best_length, overflow);
    end

    // Watchdog: end the run if no request moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned phase_start;
        target_t     goal;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        element     <= '0;
        last        <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: target at its reset value of zero
        gap_odds   = 3;
        stall_odds = 3;
        send_sequence('{16'd0, 16'd0, 16'd0});
        // window empties after the drop; the empty match must not count
        send_sequence('{16'd5, 16'd0, 16'd0});
        send_sequence('{16'hFFFF});

        // Small target: growth, drops down to one element, window emptying
        set_target(26'd10);
        send_sequence('{16'd3, 16'd7, 16'd0, 16'd10});
        send_sequence('{16'hFFFF, 16'd10});
        send_sequence('{16'd11});

        set_target(26'd65535);
        send_sequence('{16'hFFFF});
        send_sequence('{16'd65534, 16'd1, 16'd0});

        // Largest target: out of reach for a short array
        set_target(TARGET_TOP);
        send_sequence('{16'hFFFF, 16'hFFFF, 16'd1});

        // Full array of all-ones hits the largest target at full length; two
        // more elements overflow, and the second closes the array.
        gap_odds   = 0;
        stall_odds = 8;
        for (int i = 0; i < WINDOW_DEPTH + 2; i++)
            send_request(16'hFFFF, i == WINDOW_DEPTH + 1);

        // Pressure: hold off the receiver while short arrays keep coming, so
        // the result register fills and the block stalls its input.
        set_target(target_t'($urandom_range(1, 40)));
        gap_odds     = 0;
        stall_odds   = 0;
        hold_off_req = 1'b1;
        phase_start  = items_sent;
        while (items_sent - phase_start < PHASE_ITEMS)
            send_random_array();

        // Random phases over a spread of targets; the final one runs with no
        // idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       goal = '0;
                1:       goal = target_t'($urandom_range(1, 60));
                2:       goal = target_t'($urandom_range(61, 5000));
                3:       goal = target_t'($urandom_range(5001, 300000));
                4:       goal = target_t'($urandom_range(300001, TARGET_TOP));
                default: goal = target_t'($urandom_range(1, 200));
            endcase
            set_target(goal);
            if (phase == RANDOM_PHASES - 1) begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else begin
                gap_odds   = $urandom_range(2, 12);
                stall_odds = $urandom_range(2, 12);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_array();
        end

        // Drain every outstanding result, then allow a settling margin.
        close_inputs();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
